@@ rtl/geared_multiturn_angle_tracker_assert.svh @@
// assertion macros for the geared multi-turn angle tracker
`ifndef GEARED_MULTITURN_ANGLE_TRACKER_ASSERT_SVH
`define GEARED_MULTITURN_ANGLE_TRACKER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GMAT_AST_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GMAT_AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/gmat_pkg.sv @@
// shared types and constants for the geared multi-turn angle tracker
package gmat_pkg;

    // opcodes
    localparam logic [1:0] OP_UPDATE = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_ZERO   = 2'd2;
    localparam logic [1:0] OP_NOP    = 2'd3;

    // fixed field widths
    localparam int OPCODE_W  = 2;
    localparam int ANGLE_W   = 16;
    localparam int TOTAL_W   = 48;
    localparam int TURNS_W   = 32;
    localparam int RATIO_W   = 16;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd256;
    localparam logic [TURNS_W-1:0] TURNS_MAX   = 32'h7fff_ffff;
    localparam logic [TURNS_W-1:0] TURNS_MIN   = 32'h8000_0000;

    // commands from the controller to the datapath
    typedef struct packed {
        logic apply;
        logic div_load;
        logic div_step;
        logic sat;
        logic fin;
        logic publish;
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic first_pending;
        logic div_last;
    } dp_status_t;

endpackage

@@ rtl/gmat_datapath.sv @@
// unwrap, accumulate, gear divide and result registers
module gmat_datapath #(
    parameter int ANGLE_BITS = 16,
    parameter int TOTAL_BITS = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  gmat_pkg::ctrl_cmd_t              cmd,
    output gmat_pkg::dp_status_t             status,
    input  logic [gmat_pkg::OPCODE_W-1:0]    opcode,
    input  logic [gmat_pkg::ANGLE_W-1:0]     sample_angle,
    input  logic                             ratio_we,
    input  logic [gmat_pkg::RATIO_W-1:0]     ratio_value,
    output logic [gmat_pkg::ANGLE_W-1:0]     shaft_angle,
    output logic [gmat_pkg::TOTAL_W-1:0]     shaft_total,
    output logic [gmat_pkg::TURNS_W-1:0]     shaft_turns,
    output logic [gmat_pkg::ANGLE_W-1:0]     out_angle,
    output logic [gmat_pkg::TOTAL_W-1:0]     out_total,
    output logic [gmat_pkg::TURNS_W-1:0]     out_turns
);

    localparam int AB   = ANGLE_BITS;
    localparam int TB   = TOTAL_BITS;
    localparam int DW   = TB + 8;
    localparam int CNTW = $clog2(DW);
    localparam int SZW  = gmat_pkg::TURNS_W + AB;
    localparam int CW   = ((SZW > TB) ? SZW : TB) + 1;
    localparam int RW   = gmat_pkg::RATIO_W;

    localparam logic signed [AB:0]   THRESH_P = (AB+1)'(3) << (AB - 2);
    localparam logic signed [AB:0]   THRESH_N = -THRESH_P;
    localparam logic [AB:0]          TURN_BIT = (AB+1)'(1) << AB;
    localparam logic [TB-1:0]        TMAX     = {1'b0, {(TB-1){1'b1}}};
    localparam logic [TB-1:0]        TMIN     = {1'b1, {(TB-1){1'b0}}};
    localparam logic signed [TB:0]   SUM_MAX  = {2'b00, {(TB-1){1'b1}}};
    localparam logic signed [TB:0]   SUM_MIN  = {2'b11, {(TB-1){1'b0}}};
    localparam logic signed [CW-1:0] ZMAX     = {{(CW-TB+1){1'b0}}, {(TB-1){1'b1}}};
    localparam logic signed [CW-1:0] ZMIN     = {{(CW-TB+1){1'b1}}, {(TB-1){1'b0}}};
    localparam logic [DW-1:0]        LIM_POS  = {9'd0, {(TB-1){1'b1}}};
    localparam logic [DW-1:0]        LIM_NEG  = {8'd0, 1'b1, {(TB-1){1'b0}}};

    // architectural state
    logic [RW-1:0]                   ratio_reg;
    logic [AB-1:0]                   prev_reg;
    logic                            first_reg;
    logic [AB-1:0]                   latest_reg;
    logic [gmat_pkg::TURNS_W-1:0]    wrap_reg;
    logic signed [TB-1:0]            acc_reg;
    logic signed [TB-1:0]            gtot_reg;
    logic [gmat_pkg::TURNS_W-1:0]    gturns_reg;
    logic [AB-1:0]                   gangle_reg;

    // divider
    logic [DW-1:0]                   dvd_reg;
    logic [RW-1:0]                   rem_reg;
    logic [RW-1:0]                   dsr_reg;
    logic                            neg_reg;
    logic [CNTW-1:0]                 cnt_reg;

    // result registers
    logic [gmat_pkg::ANGLE_W-1:0]    shaft_angle_reg;
    logic [gmat_pkg::TOTAL_W-1:0]    shaft_total_reg;
    logic [gmat_pkg::TURNS_W-1:0]    shaft_turns_reg;
    logic [gmat_pkg::ANGLE_W-1:0]    out_angle_reg;
    logic [gmat_pkg::TOTAL_W-1:0]    out_total_reg;
    logic [gmat_pkg::TURNS_W-1:0]    out_turns_reg;

    logic [63:0]                     enc_w;
    logic [AB-1:0]                   ang_in;
    logic signed [AB:0]              diff;
    logic                            wrap_up;
    logic                            wrap_dn;
    logic [AB:0]                     delta;
    logic signed [TB:0]              sum;
    logic [TB-1:0]                   acc_upd;
    logic signed [SZW-1:0]           zprod;
    logic signed [CW-1:0]            zwide;
    logic [TB-1:0]                   acc_zero;
    logic [TB-1:0]                   mag;
    logic [RW+1:0]                   trial;
    logic                            qbit;
    logic [DW-1:0]                   lim;
    logic [TB-1:0]                   res;
    logic [TB-1:0]                   gt_val;
    logic [63:0]                     tq64;
    logic [gmat_pkg::TURNS_W-1:0]    turns_val;
    logic [63:0]                     la64;
    logic signed [63:0]              acc64;
    logic [63:0]                     ga64;
    logic signed [63:0]              gt64;

    // unwrap and saturating accumulate
    assign enc_w   = 64'(sample_angle);
    assign ang_in  = enc_w[AB-1:0];
    assign diff    = {1'b0, ang_in} - {1'b0, prev_reg};
    assign wrap_dn = diff > THRESH_P;
    assign wrap_up = diff < THRESH_N;
    // a full turn either way is the same bit pattern at this width
    assign delta   = (wrap_up || wrap_dn) ? (diff + TURN_BIT) : diff;
    assign sum     = {acc_reg[TB-1], acc_reg} + {{(TB-AB){delta[AB]}}, delta};

    always_comb
    begin
        if (sum > SUM_MAX)
            acc_upd = TMAX;
        else if (sum < SUM_MIN)
            acc_upd = TMIN;
        else
            acc_upd = sum[TB-1:0];
    end

    // set zero: wrap count times one turn, saturated
    assign zprod = {wrap_reg, {AB{1'b0}}};
    assign zwide = {{(CW-SZW){zprod[SZW-1]}}, zprod};

    always_comb
    begin
        if (zwide > ZMAX)
            acc_zero = TMAX;
        else if (zwide < ZMIN)
            acc_zero = TMIN;
        else
            acc_zero = zwide[TB-1:0];
    end

    // restoring divide, one quotient bit a cycle
    assign mag   = acc_reg[TB-1] ? (TB'(0) - acc_reg) : acc_reg;
    assign trial = {1'b0, rem_reg, dvd_reg[DW-1]} - {2'b00, dsr_reg};
    assign qbit  = !trial[RW+1];
    assign lim   = neg_reg ? LIM_NEG : LIM_POS;

    // finish: sign, turns and angle from the saturated magnitude
    assign res    = dvd_reg[TB-1:0];
    assign gt_val = neg_reg ? (TB'(0) - res) : res;
    assign tq64   = 64'(res) >> AB;

    always_comb
    begin
        if (neg_reg)
            turns_val = (tq64 > 64'h8000_0000) ? gmat_pkg::TURNS_MIN
                                               : (32'd0 - tq64[31:0]);
        else
            turns_val = (tq64 > 64'h7fff_ffff) ? gmat_pkg::TURNS_MAX : tq64[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg  <= gmat_pkg::RATIO_RESET;
            prev_reg   <= '0;
            first_reg  <= 1'b1;
            latest_reg <= '0;
            wrap_reg   <= '0;
            acc_reg    <= '0;
            gtot_reg   <= '0;
            gturns_reg <= '0;
            gangle_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (ratio_we)
                ratio_reg <= ratio_value;
            if (cmd.apply)
            begin
                unique case (opcode)
                    gmat_pkg::OP_UPDATE:
                    begin
                        latest_reg <= ang_in;
                        prev_reg   <= ang_in;
                        if (first_reg)
                            first_reg <= 1'b0;
                        else
                        begin
                            acc_reg <= acc_upd;
                            if (wrap_dn)
                                wrap_reg <= wrap_reg - 1'b1;
                            else if (wrap_up)
                                wrap_reg <= wrap_reg + 1'b1;
                        end
                    end
                    gmat_pkg::OP_CLEAR:
                    begin
                        wrap_reg   <= '0;
                        acc_reg    <= '0;
                        gtot_reg   <= '0;
                        gturns_reg <= '0;
                        first_reg  <= 1'b1;
                    end
                    gmat_pkg::OP_ZERO:
                        acc_reg <= acc_zero;
                    gmat_pkg::OP_NOP:
                        ;
                    default:
                        ;
                endcase
            end
            if (cmd.div_load)
                cnt_reg <= CNTW'(DW - 1);
            else if (cmd.div_step)
                cnt_reg <= cnt_reg - 1'b1;
            if (cmd.fin)
            begin
                gtot_reg   <= gt_val;
                gturns_reg <= turns_val;
                gangle_reg <= gt_val[AB-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            dvd_reg <= {mag, 8'd0};
            rem_reg <= '0;
            neg_reg <= acc_reg[TB-1];
            dsr_reg <= (ratio_reg == '0) ? RW'(1) : ratio_reg;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[DW-2:0], qbit};
            if (qbit)
                rem_reg <= trial[RW-1:0];
            else
                rem_reg <= {rem_reg[RW-2:0], dvd_reg[DW-1]};
        end
        else if (cmd.sat)
        begin
            if (dvd_reg > lim)
                dvd_reg <= lim;
        end
    end

    // result snapshot, fitted to the field widths
    assign la64  = 64'(latest_reg);
    assign acc64 = 64'(acc_reg);
    assign ga64  = 64'(gangle_reg);
    assign gt64  = 64'(gtot_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            shaft_angle_reg <= la64[gmat_pkg::ANGLE_W-1:0];
            shaft_total_reg <= acc64[gmat_pkg::TOTAL_W-1:0];
            shaft_turns_reg <= wrap_reg;
            out_angle_reg   <= ga64[gmat_pkg::ANGLE_W-1:0];
            out_total_reg   <= gt64[gmat_pkg::TOTAL_W-1:0];
            out_turns_reg   <= gturns_reg;
        end
    end

    assign status.first_pending = first_reg;
    assign status.div_last      = (cnt_reg == '0);

    assign shaft_angle = shaft_angle_reg;
    assign shaft_total = shaft_total_reg;
    assign shaft_turns = shaft_turns_reg;
    assign out_angle   = out_angle_reg;
    assign out_total   = out_total_reg;
    assign out_turns   = out_turns_reg;

endmodule

@@ rtl/gmat_ctrl.sv @@
// sequencing state machine for the geared multi-turn angle tracker
`include "geared_multiturn_angle_tracker_assert.svh"

module gmat_ctrl (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [gmat_pkg::OPCODE_W-1:0] opcode,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  gmat_pkg::dp_status_t          status,
    output gmat_pkg::ctrl_cmd_t           cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SAT  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_PUB  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;
    logic       need_div;
    logic       pub_ok;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign pub_ok   = !out_valid_reg || out_ready;

    // geared values are recomputed by any tracking update but the first after reset or clear, or a zero set
    always_comb
    begin
        need_div = 1'b0;
        unique case (opcode) inside
            gmat_pkg::OP_UPDATE:                   need_div = !status.first_pending;
            gmat_pkg::OP_ZERO:                     need_div = 1'b1;
            gmat_pkg::OP_CLEAR, gmat_pkg::OP_NOP:  need_div = 1'b0;
            default:                               need_div = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept) state_next = need_div ? S_LOAD : S_PUB;
            S_LOAD: state_next = S_DIV;
            S_DIV:  if (status.div_last) state_next = S_SAT;
            S_SAT:  state_next = S_FIN;
            S_FIN:  state_next = S_PUB;
            S_PUB:  if (pub_ok) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign cmd.apply    = accept;
    assign cmd.div_load = (state_reg == S_LOAD);
    assign cmd.div_step = (state_reg == S_DIV);
    assign cmd.sat      = (state_reg == S_SAT);
    assign cmd.fin      = (state_reg == S_FIN);
    assign cmd.publish  = (state_reg == S_PUB) && pub_ok;

    assign out_valid_next = cmd.publish ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `GMAT_AST_IMPL(a_pub_free, cmd.publish, !out_valid_reg || out_ready, "result overwritten")
    `GMAT_AST_NEXT(a_div_entry, accept && need_div, state_reg == S_LOAD, "divide not started")
    `GMAT_AST_NEXT(a_div_exit, (state_reg == S_DIV) && status.div_last, state_reg == S_SAT, "divide overrun")
    `GMAT_AST_NEXT(a_pub_valid, cmd.publish, out_valid_reg, "published item not shown")

endmodule

@@ rtl/geared_multiturn_angle_tracker.sv @@
// top level of the geared multi-turn angle tracker
//
//  channel   handshake                 payload
//  -------   ---------------------     ---------------------------------------------
//  in        in_valid / in_ready       opcode, sample_angle
//  out       out_valid / out_ready     shaft_angle, shaft_total, shaft_turns,
//                                      out_angle, out_total, out_turns
//  config    ratio_we                  ratio_value
//
//  update items (but the first after reset or clear) and set-zero items run the
//  gear divide on the one-bit-a-cycle restoring divider over TOTAL_BITS + 8
//  quotient bits, then saturate and finish; other items go straight to publish
//  in_ready is high only while the sequencer is idle; one item is in work at a time
//  the result register lets the next item start while a result waits on out_ready
//  reset (rst_n low, asynchronous) clears all counters and sets the ratio to 1:1
module geared_multiturn_angle_tracker #(
    parameter int ANGLE_BITS = 16,
    parameter int TOTAL_BITS = 48
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // item input
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [gmat_pkg::OPCODE_W-1:0]    opcode,
    input  logic [gmat_pkg::ANGLE_W-1:0]     sample_angle,
    // gear ratio register, unsigned q8.8
    input  logic                             ratio_we,
    input  logic [gmat_pkg::RATIO_W-1:0]     ratio_value,
    // item output
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [gmat_pkg::ANGLE_W-1:0]     shaft_angle,
    output logic [gmat_pkg::TOTAL_W-1:0]     shaft_total,
    output logic [gmat_pkg::TURNS_W-1:0]     shaft_turns,
    output logic [gmat_pkg::ANGLE_W-1:0]     out_angle,
    output logic [gmat_pkg::TOTAL_W-1:0]     out_total,
    output logic [gmat_pkg::TURNS_W-1:0]     out_turns
);

    // commands down, status up
    gmat_pkg::ctrl_cmd_t  cmd;
    gmat_pkg::dp_status_t status;

    // sequencer: accept, divide, saturate, finish, publish
    gmat_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // unwrap, saturating totals, gear divide and the result register
    gmat_datapath #(
        .ANGLE_BITS (ANGLE_BITS),
        .TOTAL_BITS (TOTAL_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (opcode),
        .sample_angle (sample_angle),
        .ratio_we     (ratio_we),
        .ratio_value  (ratio_value),
        .shaft_angle  (shaft_angle),
        .shaft_total  (shaft_total),
        .shaft_turns  (shaft_turns),
        .out_angle    (out_angle),
        .out_total    (out_total),
        .out_turns    (out_turns)
    );

endmodule
